// ===== rtl/core/dtbc_pkg.sv =====
package dtbc_pkg;

   localparam int CNT_W      = 17;
   localparam int START_W    = 31;
   localparam int CYL_W      = 31;
   localparam int ADDR_MAX_W = 47;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_END     = 2'd1,
      ST_INVALID = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_SECTOR_SIZE    = 2'd0,
      CSR_SECTORS_PER_CYL = 2'd1,
      CSR_WHOLE_DISK_OFF = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] sector_size;
      logic [15:0] sectors_per_cylinder;
      logic [31:0] whole_disk_offset;
   } cfg_type;

   // One classified request on its way to the cylinder divider.
   typedef struct packed {
      logic                    proceed;
      status_type              status;
      logic [CNT_W-1:0]        adj;
      logic [CNT_W-1:0]        resid;
      logic [ADDR_MAX_W-1:0]   addr;
   } job_type;

endpackage

// ===== rtl/core/disk_transfer_bounds_check_core.sv =====
// Disk transfer bounds checker. Each request word is checked against its
// partition and answered by exactly one response word, in order. A new request is
// accepted every cycle while req_stall is low. A request passes through ADDR_BITS + 3
// registers, the first loaded at the accepting edge: two front stages for the sector
// scaling multiplies and the classification, a queue entry, an entry stage of the cylinder
// divider and one stage per quotient bit (ADDR_BITS - 1 of them).
// Configuration writes are taken every cycle and must only be issued while no
// request is in flight.
module disk_transfer_bounds_check_core #(
   parameter int BLOCK_SHIFT  = 9,
   parameter int LABEL_SECTOR = 1,
   parameter int ADDR_BITS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [31:0]                     csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dtbc_pkg::START_W-1:0]    req_start_block,
   input  logic [dtbc_pkg::CNT_W-1:0]      req_byte_count,
   input  logic                            req_is_read,
   input  logic                            req_label_write_enabled,
   input  logic [31:0]                     req_partition_offset,
   input  logic [31:0]                     req_partition_size,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_proceed,
   output logic [1:0]                      rsp_status,
   output logic [dtbc_pkg::CNT_W-1:0]      rsp_adjusted_byte_count,
   output logic [dtbc_pkg::CNT_W-1:0]      rsp_residual_bytes,
   output logic [dtbc_pkg::CYL_W-1:0]      rsp_cylinder
);

   dtbc_pkg::cfg_type cfg_ff, cfg_in;
   logic              fr_valid, q_full, q_not_empty, q_pop;
   logic [1:0]        q_count;
   dtbc_pkg::job_type fr_job, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dtbc_pkg::CSR_SECTOR_SIZE:     cfg_in.sector_size          = csr_data[15:0];
            dtbc_pkg::CSR_SECTORS_PER_CYL: cfg_in.sectors_per_cylinder = csr_data[15:0];
            dtbc_pkg::CSR_WHOLE_DISK_OFF:  cfg_in.whole_disk_offset    = csr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sector_size          <= 16'd512;
         cfg_ff.sectors_per_cylinder <= 16'd100;
         cfg_ff.whole_disk_offset    <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtbc_front #(
      .BLOCK_SHIFT  (BLOCK_SHIFT),
      .LABEL_SECTOR (LABEL_SECTOR),
      .ADDR_BITS    (ADDR_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .in_valid            (req_valid),
      .in_stall            (req_stall),
      .start_block         (req_start_block),
      .byte_count          (req_byte_count),
      .is_read             (req_is_read),
      .label_write_enabled (req_label_write_enabled),
      .partition_offset    (req_partition_offset),
      .partition_size      (req_partition_size),
      .out_valid           (fr_valid),
      .out_full            (q_full),
      .out_job             (fr_job)
   );

   dtbc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid && !q_full),
      .push_job  (fr_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (q_head),
      .count     (q_count)
   );

   dtbc_back #(
      .BLOCK_SHIFT (BLOCK_SHIFT),
      .ADDR_BITS   (ADDR_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (q_not_empty),
      .in_pop       (q_pop),
      .in_job       (q_head),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_proceed  (rsp_proceed),
      .out_status   (rsp_status),
      .out_adj      (rsp_adjusted_byte_count),
      .out_resid    (rsp_residual_bytes),
      .out_cylinder (rsp_cylinder)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3)
      else $error("queue count out of range");

   a_queue_no_over: assert property (@(posedge clock) disable iff (reset)
      q_full && !q_pop |=> q_full)
      else $error("queue lost a word while full");

   a_proceed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_proceed |-> rsp_status == dtbc_pkg::ST_OK && rsp_residual_bytes == '0)
      else $error("proceed without clean status");

   a_refused_cyl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_proceed |-> rsp_cylinder == '0)
      else $error("cylinder given for a refused word");

endmodule

// ===== rtl/core/dtbc_front.sv =====
module dtbc_front #(
   parameter int BLOCK_SHIFT  = 9,
   parameter int LABEL_SECTOR = 1,
   parameter int ADDR_BITS    = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dtbc_pkg::cfg_type                  cfg,
   input  logic                               in_valid,
   output logic                               in_stall,
   input  logic [dtbc_pkg::START_W-1:0]       start_block,
   input  logic [dtbc_pkg::CNT_W-1:0]         byte_count,
   input  logic                               is_read,
   input  logic                               label_write_enabled,
   input  logic [31:0]                        partition_offset,
   input  logic [31:0]                        partition_size,
   output logic                               out_valid,
   input  logic                               out_full,
   output dtbc_pkg::job_type                  out_job
);

   localparam int SC_W   = 16 - BLOCK_SHIFT;
   localparam int BLK_W  = 18 - BLOCK_SHIFT;
   localparam int PROD_W = 32 + SC_W;
   localparam int LBL_W  = 33 + SC_W;
   localparam int WW     = (34 + SC_W > ADDR_BITS + 1) ? 34 + SC_W : ADDR_BITS + 1;
   localparam int CNT_W_L = dtbc_pkg::CNT_W + 1;

   logic                en;
   logic [SC_W-1:0]     sc;
   logic [PROD_W-1:0]   psize_mul;
   logic [PROD_W-1:0]   poffs_mul;
   logic [LBL_W-1:0]    label_mul;
   logic [32:0]         label_base;
   logic [BLK_W-1:0]    blocks;
   logic [CNT_W_L-1:0]  count_round;

   logic                          a_v_ff, a_v_in;
   logic [dtbc_pkg::START_W-1:0]  a_start_ff;
   logic [dtbc_pkg::CNT_W-1:0]    a_count_ff;
   logic [BLK_W-1:0]              a_blocks_ff;
   logic                          a_rd_ff, a_wl_ff, a_scz_ff;
   logic [WW-1:0]                 a_psize_ff, a_poffs_ff, a_label_ff;

   logic                          b_v_ff, b_v_in;
   dtbc_pkg::job_type             b_job_ff, b_job_in;

   logic [WW-1:0] start_w, sum, blocks_eff, abs_start, abs_end, adj_w;
   logic          over, addr_ovf, lbl_hit;

   assign en       = !b_v_ff || !out_full;
   assign in_stall = !en;

   assign sc          = cfg.sector_size[15:BLOCK_SHIFT];
   assign psize_mul   = PROD_W'(partition_size) * PROD_W'(sc);
   assign poffs_mul   = PROD_W'(partition_offset) * PROD_W'(sc);
   assign label_base  = 33'(cfg.whole_disk_offset) + 33'(LABEL_SECTOR);
   assign label_mul   = LBL_W'(label_base) * LBL_W'(sc);
   assign count_round = CNT_W_L'(byte_count) + CNT_W_L'((1 << BLOCK_SHIFT) - 1);
   assign blocks      = BLK_W'(count_round >> BLOCK_SHIFT);

   assign a_v_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= a_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_start_ff  <= start_block;
         a_count_ff  <= byte_count;
         a_blocks_ff <= blocks;
         a_rd_ff     <= is_read;
         a_wl_ff     <= label_write_enabled;
         a_scz_ff    <= (sc == '0);
         a_psize_ff  <= WW'(psize_mul);
         a_poffs_ff  <= WW'(poffs_mul);
         a_label_ff  <= WW'(label_mul);
      end
   end

   assign start_w    = WW'(a_start_ff);
   assign sum        = start_w + WW'(a_blocks_ff);
   assign over       = sum > a_psize_ff;
   assign blocks_eff = over ? a_psize_ff - start_w : WW'(a_blocks_ff);
   assign abs_start  = start_w + a_poffs_ff;
   assign abs_end    = abs_start + blocks_eff;
   assign addr_ovf   = abs_end >= (WW'(1) << (ADDR_BITS - 1));
   assign lbl_hit    = (abs_start <= a_label_ff) &&
                       ((LABEL_SECTOR == 0) || (abs_end > a_label_ff)) &&
                       !a_rd_ff && !a_wl_ff;
   assign adj_w      = blocks_eff << BLOCK_SHIFT;

   always_comb begin
      b_job_in.proceed = 1'b0;
      b_job_in.status  = dtbc_pkg::ST_INVALID;
      b_job_in.adj     = '0;
      b_job_in.resid   = a_count_ff;
      b_job_in.addr    = dtbc_pkg::ADDR_MAX_W'(abs_start[ADDR_BITS-2:0]);
      if (a_scz_ff) begin
         b_job_in.status = dtbc_pkg::ST_INVALID;
      end else if (over && (start_w == a_psize_ff)) begin
         b_job_in.status = dtbc_pkg::ST_END;
         b_job_in.adj    = a_count_ff;
      end else if (over && (start_w > a_psize_ff)) begin
         b_job_in.status = dtbc_pkg::ST_INVALID;
      end else if (addr_ovf) begin
         b_job_in.status = dtbc_pkg::ST_INVALID;
      end else if (lbl_hit) begin
         b_job_in.status = dtbc_pkg::ST_REFUSED;
      end else begin
         b_job_in.proceed = 1'b1;
         b_job_in.status  = dtbc_pkg::ST_OK;
         b_job_in.adj     = over ? adj_w[dtbc_pkg::CNT_W-1:0] : a_count_ff;
         b_job_in.resid   = '0;
      end
   end

   assign b_v_in = a_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= b_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_job_ff <= b_job_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_job   = b_job_ff;

endmodule

// ===== rtl/core/dtbc_fifo.sv =====
module dtbc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dtbc_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output dtbc_pkg::job_type head_job,
   output logic [1:0]        count
);

   dtbc_pkg::job_type mem [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_job  = mem[rptr_ff];
   assign count     = count_ff;

   assign wptr_in  = push ? !wptr_ff : wptr_ff;
   assign rptr_in  = pop ? !rptr_ff : rptr_ff;
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/dtbc_back.sv =====
module dtbc_back #(
   parameter int BLOCK_SHIFT = 9,
   parameter int ADDR_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dtbc_pkg::cfg_type               cfg,
   input  logic                            in_valid,
   output logic                            in_pop,
   input  dtbc_pkg::job_type               in_job,
   output logic                            out_valid,
   input  logic                            out_stall,
   output logic                            out_proceed,
   output logic [1:0]                      out_status,
   output logic [dtbc_pkg::CNT_W-1:0]      out_adj,
   output logic [dtbc_pkg::CNT_W-1:0]      out_resid,
   output logic [dtbc_pkg::CYL_W-1:0]      out_cylinder
);

   localparam int SC_W = 16 - BLOCK_SHIFT;
   localparam int DW   = SC_W + 16;
   localparam int N    = ADDR_BITS - 1;
   localparam int QX   = (N > dtbc_pkg::CYL_W) ? N : dtbc_pkg::CYL_W + 1;

   logic en;
   logic [DW-1:0] d_ff, d_in;

   logic              v_ff   [N+1];
   dtbc_pkg::job_type job_ff [N+1];
   logic [DW-1:0]     rem_ff [N+1];
   logic [N-1:0]      q_ff   [N+1];

   logic [QX-1:0] qx;

   assign en     = !v_ff[N] || !out_stall;
   assign in_pop = en && in_valid;

   // Divisor for the combined division (abs_start / sc) / sectors_per_cylinder.
   assign d_in = DW'(cfg.sector_size[15:BLOCK_SHIFT]) * DW'(cfg.sectors_per_cylinder);

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff[0] <= in_job;
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar s = 0; s < N; s++) begin : g_div
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;

      assign trial = {rem_ff[s], job_ff[s].addr[N-1-s]};
      assign ge    = trial >= {1'b0, d_ff};
      assign diff  = trial - {1'b0, d_ff};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            job_ff[s+1] <= job_ff[s];
            rem_ff[s+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_ff[s+1]   <= {q_ff[s][N-2:0], ge};
         end
      end
   end

   assign qx = QX'(q_ff[N]);

   always_comb begin
      out_cylinder = qx[dtbc_pkg::CYL_W-1:0];
      if (|qx[QX-1:dtbc_pkg::CYL_W]) begin
         out_cylinder = '1;
      end
      if (!job_ff[N].proceed || (cfg.sectors_per_cylinder == '0)) begin
         out_cylinder = '0;
      end
   end

   assign out_valid   = v_ff[N];
   assign out_proceed = job_ff[N].proceed;
   assign out_status  = job_ff[N].status;
   assign out_adj     = job_ff[N].adj;
   assign out_resid   = job_ff[N].resid;

endmodule
